### sv/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg: shared types and codes for the shortest-remaining-time scheduler
// Holds the task table row layout, request opcodes, result status codes
// and the sequencer state type.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    STAT_ACCEPTED = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_RAN      = 2'd2,
    STAT_IDLE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARR_SCAN,
    S_TICK_SCAN,
    S_TICK_DRAIN,
    S_FINISH
  } fsm_t;

  // One task table entry as held in the slot memory.
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [15:0] left;
    logic [15:0] start;
  } row_t;

  localparam int ROW_W = $bits(row_t);

endpackage

### sv/srt_ram.sv
// ----------------------------------------------------------------------------
// srt_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module srt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/shortest_remaining_time_scheduler.sv
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler: preemptive SRTF task scheduler
// An arrive request scans the valid bits for a free slot, one slot per cycle,
// and then registers its result in the finish state.
// A tick request does one slot-memory read per cycle, drains the read
// pipeline, then does one read-modify-write in the finish state.
// Only one request is handled at a time; new requests stall until it ends.
// Reset (synchronous, rst_n low) empties the table and zeroes the tick count.
// ----------------------------------------------------------------------------
module shortest_remaining_time_scheduler #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_task_id,
  input  logic [15:0] in_burst,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [7:0]  out_run_id,
  output logic        out_finished,
  output logic [15:0] out_start_tick,
  output logic [15:0] out_wait_ticks
);

  localparam int IdxW = $clog2(SLOTS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  // --------------------------------------------------------------------------
  // State. The per-slot payload (id, arrival, burst, remaining time, start
  // tick) lives in one slot memory. Only the valid bits are flip-flops, so
  // reset empties the table at once without a clearing pass.
  // --------------------------------------------------------------------------
  srt_pkg::fsm_t    state_r, state_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [15:0]      now_tick_r, now_tick_nxt;
  logic [IdxW-1:0]  idx_r, idx_nxt;
  logic             rd_vld_r, rd_vld_nxt;

  // Captured request.
  logic             op_r;
  logic [7:0]       id_r;
  logic [15:0]      burst_r;

  // Scan results.
  logic             free_found_r, free_found_nxt;
  logic             have_best_r, have_best_nxt;
  logic [IdxW-1:0]  best_idx_r, best_idx_nxt;
  srt_pkg::row_t    best_row_r, best_row_nxt;
  logic [IdxW-1:0]  rd_idx_r;

  // Result register.
  logic             out_valid_r, out_valid_nxt;
  srt_pkg::status_t out_status_r, out_status_nxt;
  logic [7:0]       out_run_id_r, out_run_id_nxt;
  logic             out_finished_r, out_finished_nxt;
  logic [15:0]      out_start_r, out_start_nxt;
  logic [15:0]      out_wait_r, out_wait_nxt;

  // Slot memory port signals.
  logic                       ram_we, ram_re;
  logic [IdxW-1:0]            ram_waddr;
  srt_pkg::row_t              ram_wrow, rd_row;
  logic [srt_pkg::ROW_W-1:0]  ram_rdata;

  srt_ram #(
    .WIDTH (srt_pkg::ROW_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wrow),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign rd_row = srt_pkg::row_t'(ram_rdata);

  // --------------------------------------------------------------------------
  // Finish-cycle arithmetic for a tick request, from the winning row.
  // The finish tick is the next tick count (saturating). The waiting time is
  // formed in 18 bits so that a negative result, possible only after the
  // counter saturates, can be clamped to zero.
  // --------------------------------------------------------------------------
  logic [15:0] next_tick;
  logic [15:0] left_new, start_new;
  logic        task_done;
  logic [17:0] wait_full;
  logic [15:0] burst_eff;
  logic        in_acc, out_free, take_best;

  assign next_tick = (now_tick_r == srt_pkg::TICK_MAX) ? now_tick_r : now_tick_r + 16'd1;
  assign start_new = (best_row_r.left == best_row_r.burst) ? now_tick_r : best_row_r.start;
  assign left_new  = (best_row_r.left == 16'd0) ? 16'd0 : best_row_r.left - 16'd1;
  assign task_done = (left_new == 16'd0);
  assign wait_full = {2'b00, next_tick} - {2'b00, best_row_r.burst}
                   - {2'b00, best_row_r.arrival};
  // A zero burst is stored as one tick of work.
  assign burst_eff = (burst_r == 16'd0) ? 16'd1 : burst_r;

  // New requests are taken only while the sequencer is idle.
  assign in_stall = (state_r != srt_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // A returning read competes for the best slot: strictly less remaining
  // time wins, so on a tie the lower slot, seen first, is kept.
  assign take_best = rd_vld_r && valid_r[rd_idx_r]
                   && (!have_best_r || (rd_row.left < best_row_r.left));

  // --------------------------------------------------------------------------
  // Sequencer. Reads happen only during the tick scan and the single write
  // happens only in the finish cycle, so the memory never sees a read and a
  // write to the same slot overlap; no forwarding path is needed.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt        = state_r;
    valid_nxt        = valid_r;
    now_tick_nxt     = now_tick_r;
    idx_nxt          = idx_r;
    rd_vld_nxt       = 1'b0;
    free_found_nxt   = free_found_r;
    have_best_nxt    = have_best_r;
    best_idx_nxt     = best_idx_r;
    best_row_nxt     = best_row_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_status_nxt   = out_status_r;
    out_run_id_nxt   = out_run_id_r;
    out_finished_nxt = out_finished_r;
    out_start_nxt    = out_start_r;
    out_wait_nxt     = out_wait_r;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_waddr        = best_idx_r;
    ram_wrow         = best_row_r;

    if (take_best) begin
      have_best_nxt = 1'b1;
      best_idx_nxt  = rd_idx_r;
      best_row_nxt  = rd_row;
    end

    case (state_r)
      srt_pkg::S_IDLE: begin
        if (in_acc) begin
          idx_nxt        = '0;
          have_best_nxt  = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = (in_opcode == srt_pkg::OP_TICK) ? srt_pkg::S_TICK_SCAN
                                                           : srt_pkg::S_ARR_SCAN;
        end
      end

      srt_pkg::S_ARR_SCAN: begin
        if (!valid_r[idx_r]) begin
          free_found_nxt = 1'b1;
          best_idx_nxt   = idx_r;
          state_nxt      = srt_pkg::S_FINISH;
        end else if (idx_r == LastIdx) begin
          state_nxt = srt_pkg::S_FINISH;
        end else begin
          idx_nxt = idx_r + IdxW'(1);
        end
      end

      srt_pkg::S_TICK_SCAN: begin
        ram_re     = 1'b1;
        rd_vld_nxt = 1'b1;
        if (idx_r == LastIdx) begin
          state_nxt = srt_pkg::S_TICK_DRAIN;
        end else begin
          idx_nxt = idx_r + IdxW'(1);
        end
      end

      srt_pkg::S_TICK_DRAIN: begin
        state_nxt = srt_pkg::S_FINISH;
      end

      srt_pkg::S_FINISH: begin
        if (out_free) begin
          state_nxt        = srt_pkg::S_IDLE;
          out_valid_nxt    = 1'b1;
          out_finished_nxt = 1'b0;
          out_start_nxt    = 16'd0;
          out_wait_nxt     = 16'd0;
          if (op_r == srt_pkg::OP_ARRIVE) begin
            out_run_id_nxt = id_r;
            if (free_found_r) begin
              out_status_nxt        = srt_pkg::STAT_ACCEPTED;
              ram_we                = 1'b1;
              ram_wrow.id           = id_r;
              ram_wrow.arrival      = now_tick_r;
              ram_wrow.burst        = burst_eff;
              ram_wrow.left         = burst_eff;
              ram_wrow.start        = 16'd0;
              valid_nxt[best_idx_r] = 1'b1;
            end else begin
              out_status_nxt = srt_pkg::STAT_FULL;
            end
          end else begin
            now_tick_nxt = next_tick;
            if (!have_best_r) begin
              out_status_nxt = srt_pkg::STAT_IDLE;
              out_run_id_nxt = 8'd0;
            end else begin
              out_status_nxt = srt_pkg::STAT_RAN;
              out_run_id_nxt = best_row_r.id;
              ram_we         = 1'b1;
              ram_wrow.left  = left_new;
              ram_wrow.start = start_new;
              if (task_done) begin
                out_finished_nxt      = 1'b1;
                out_start_nxt         = start_new;
                out_wait_nxt          = wait_full[17] ? 16'd0 : wait_full[15:0];
                valid_nxt[best_idx_r] = 1'b0;
              end
            end
          end
        end
      end

      default: begin
        state_nxt = srt_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srt_pkg::S_IDLE;
      valid_r     <= '0;
      now_tick_r  <= 16'd0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      now_tick_r  <= now_tick_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_opcode;
      id_r    <= in_task_id;
      burst_r <= in_burst;
    end
    idx_r          <= idx_nxt;
    rd_idx_r       <= idx_r;
    free_found_r   <= free_found_nxt;
    have_best_r    <= have_best_nxt;
    best_idx_r     <= best_idx_nxt;
    best_row_r     <= best_row_nxt;
    out_status_r   <= out_status_nxt;
    out_run_id_r   <= out_run_id_nxt;
    out_finished_r <= out_finished_nxt;
    out_start_r    <= out_start_nxt;
    out_wait_r     <= out_wait_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_run_id     = out_run_id_r;
  assign out_finished   = out_finished_r;
  assign out_start_tick = out_start_r;
  assign out_wait_ticks = out_wait_r;

  // --------------------------------------------------------------------------
  // Checks.
  // --------------------------------------------------------------------------
  // The memory is never read and written in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("slot memory read and write overlap");

  // Returning read data only arrives during the tick scan or its drain.
  a_read_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == srt_pkg::S_TICK_SCAN || state_r == srt_pkg::S_TICK_DRAIN))
    else $error("stray slot memory read data");

  // The tick counter never runs backwards.
  a_tick_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (now_tick_r >= $past(now_tick_r)))
    else $error("tick counter decreased");

  // A reported finish frees a slot in the same cycle it is reported.
  a_finish_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == srt_pkg::S_FINISH && out_free && op_r == srt_pkg::OP_TICK
     && have_best_r && task_done) |=> !valid_r[$past(best_idx_r)])
    else $error("finished task still holds its slot");

endmodule

### sim/tb_shortest_remaining_time_scheduler.sv
// ----------------------------------------------------------------------------
// tb_shortest_remaining_time_scheduler: self-checking bench for the SRTF scheduler
// A scoreboard class holds its own model of the task table and the tick
// counter. It predicts one result for every accepted request and compares
// each result, field by field and in order. Stimulus is a short directed
// pass followed by random traffic.
// ----------------------------------------------------------------------------
module tb_shortest_remaining_time_scheduler;

  localparam int SLOTS           = 16;
  localparam int RANDOM_REQUESTS = 1900;
  // Cycle limit for the watchdog. It leaves plenty of margin above the
  // slowest correct run.
  localparam int CYCLE_LIMIT     = 400_000;
  // Length of each long receiver hold-off, in cycles.
  localparam int LONG_HOLD       = 300;
  // Mismatch lines beyond this count are still counted but not printed.
  localparam int PRINT_CAP       = 100;

  // One result as seen on the output ports.
  typedef struct {
    logic [1:0]  status;
    logic [7:0]  run_id;
    logic        finished;
    logic [15:0] start_tick;
    logic [15:0] wait_ticks;
  } sched_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: a private copy of the task table and the tick counter. Each
  // accepted request updates the table and queues the result that it causes.
  // Each result from the block is checked against the oldest queued one.
  // --------------------------------------------------------------------------
  class srt_scoreboard;
    bit            busy       [SLOTS];
    bit [7:0]      task_of    [SLOTS];
    bit [15:0]     arrived_at [SLOTS];
    bit [15:0]     burst_of   [SLOTS];
    bit [15:0]     left_of    [SLOTS];
    bit [15:0]     started_at [SLOTS];
    bit [15:0]     now_tick;
    sched_result_t pending_results[$];
    int            mismatches;
    int            results_seen;

    function new();
      now_tick     = 16'd0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    // The tick counter sticks at its top value instead of wrapping.
    function bit [15:0] saturating_next(bit [15:0] t);
      return (t == srt_pkg::TICK_MAX) ? srt_pkg::TICK_MAX : t + 16'd1;
    endfunction

    function void note_request(logic op, logic [7:0] id, logic [15:0] burst);
      sched_result_t r;
      int            pick;
      int            w;
      bit [15:0]     finish;
      r    = '{srt_pkg::STAT_ACCEPTED, id, 1'b0, 16'd0, 16'd0};
      pick = -1;
      if (op == srt_pkg::OP_ARRIVE) begin
        // The lowest free slot takes the task.
        for (int k = 0; k < SLOTS; k++) begin
          if (!busy[k]) begin
            pick = k;
            break;
          end
        end
        if (pick < 0) begin
          r.status = srt_pkg::STAT_FULL;
        end else begin
          // A zero burst is treated as a one-tick task.
          if (burst == 16'd0) begin
            burst = 16'd1;
          end
          busy[pick]       = 1'b1;
          task_of[pick]    = id;
          arrived_at[pick] = now_tick;
          burst_of[pick]   = burst;
          left_of[pick]    = burst;
          started_at[pick] = 16'd0;
        end
      end else begin
        r.run_id = 8'd0;
        // Least remaining time wins; a strict compare keeps the lowest slot on ties.
        for (int k = 0; k < SLOTS; k++) begin
          if (busy[k] && (pick < 0 || left_of[k] < left_of[pick])) begin
            pick = k;
          end
        end
        if (pick < 0) begin
          r.status = srt_pkg::STAT_IDLE;
          now_tick = saturating_next(now_tick);
        end else begin
          finish   = saturating_next(now_tick);
          r.status = srt_pkg::STAT_RAN;
          r.run_id = task_of[pick];
          if (left_of[pick] == burst_of[pick]) begin
            started_at[pick] = now_tick;
          end
          left_of[pick] = left_of[pick] - 16'd1;
          if (left_of[pick] == 16'd0) begin
            // Once the counter saturates this can go negative; it is floored at zero.
            w = int'(finish) - int'(burst_of[pick]) - int'(arrived_at[pick]);
            if (w < 0) begin
              w = 0;
            end
            r.finished   = 1'b1;
            r.start_tick = started_at[pick];
            r.wait_ticks = w[15:0];
            busy[pick]   = 1'b0;
          end
          now_tick = finish;
        end
      end
      pending_results.insert(pending_results.size(), r);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) begin
        $display("MISMATCH @%0t: %s", $time, msg);
      end
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
        report($sformatf("result %0d %s: got %0h, expected %0h",
                         results_seen, name, got, want));
      end
    endtask

    task check_result(sched_result_t got);
      sched_result_t want;
      results_seen++;
      if (pending_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected (status %0d, id %0h)",
                         results_seen, got.status, got.run_id));
        return;
      end
      want = pending_results.pop_front();
      compare_field("status",     16'(got.status),   16'(want.status));
      compare_field("run_id",     16'(got.run_id),   16'(want.run_id));
      compare_field("finished",   16'(got.finished), 16'(want.finished));
      compare_field("start_tick", got.start_tick,    want.start_tick);
      compare_field("wait_ticks", got.wait_ticks,    want.wait_ticks);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Block under test and its signals. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic        in_opcode      = srt_pkg::OP_ARRIVE;
  logic [7:0]  in_task_id     = 8'd0;
  logic [15:0] in_burst       = 16'd0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [1:0]  out_status;
  logic [7:0]  out_run_id;
  logic        out_finished;
  logic [15:0] out_start_tick;
  logic [15:0] out_wait_ticks;

  shortest_remaining_time_scheduler #(.SLOTS(SLOTS)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_task_id     (in_task_id),
    .in_burst       (in_burst),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_run_id     (out_run_id),
    .out_finished   (out_finished),
    .out_start_tick (out_start_tick),
    .out_wait_ticks (out_wait_ticks)
  );

  srt_scoreboard sb = new();

  // When set, the sender draws a random gap before each request and the receiver
  // a random stall after each result. Stretches with both cleared run at the block's full rate.
  bit tx_idling = 1'b1;
  bit rx_idling = 1'b1;

  // The stimulus bumps holds_requested to ask for one long receiver hold-off.
  // The receiver bumps holds_served when it takes the request up, so each
  // counter has exactly one writer.
  int holds_requested = 0;
  int holds_served    = 0;
  int requests_sent   = 0;
  int cycle_count     = 0;

  initial begin : clock_gen
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** shortest_remaining_time_scheduler: FAILED **");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side. A result is taken at an edge where out_valid is high and
  // out_stall is low. Every input is driven with nonblocking assignments at
  // the edge, so values sampled right after the edge are the pre-edge ones.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int            stall_left;
    int            hold_left;
    sched_result_t got;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        got = '{out_status, out_run_id, out_finished, out_start_tick, out_wait_ticks};
        sb.check_result(got);
        stall_left = rx_idling ? $urandom_range(0, 3) : 0;
      end
      if (holds_served != holds_requested) begin
        hold_left = LONG_HOLD;
        holds_served++;
      end
      // Exactly one assignment to out_stall per edge.
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side. A task call starts right after an edge. When the previous
  // request was just taken, valid is either lowered for a gap or kept high
  // with the new payload, never both in one time step.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic op, input logic [7:0] id, input logic [15:0] burst);
    int gap;
    gap = tx_idling ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_task_id <= id;
    in_burst   <= burst;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_request(op, id, burst);
    requests_sent++;
  endtask

  // Stop offering requests and wait until every expected result is back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // Mostly short bursts so tasks keep finishing. Zero bursts, mid-sized ones
  // and a rare long one keep every burst bit moving without jamming the table.
  function automatic logic [15:0] pick_burst();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 16'd0;
    if (r < 83) return 16'($urandom_range(1, 8));
    if (r < 98) return 16'($urandom_range(9, 255));
    return 16'($urandom_range(256, 65535));
  endfunction

  task automatic send_random_tick();
    send_request(srt_pkg::OP_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
  endtask

  // Directed opening: a tick on an empty table, a zero-burst task, a full
  // table with ties on remaining time, a rejected arrival, then ticks on the ties.
  task automatic run_directed();
    logic [7:0]  ids    [16] = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55, 8'hAA,
                                 8'h10, 8'h20, 8'h40, 8'h08, 8'h04, 8'h02, 8'hC3, 8'h3C};
    logic [15:0] bursts [16] = '{16'hFFFF, 16'd4, 16'd2, 16'd2, 16'd7, 16'h8000, 16'd3,
                                 16'd2, 16'd1, 16'd5, 16'd0, 16'd9, 16'd6, 16'h0100,
                                 16'h7FFF, 16'd2};
    send_request(srt_pkg::OP_TICK, 8'h00, 16'h0000);
    send_request(srt_pkg::OP_ARRIVE, 8'h00, 16'h0000);
    send_request(srt_pkg::OP_TICK, 8'hFF, 16'hFFFF);
    foreach (ids[k]) begin
      send_request(srt_pkg::OP_ARRIVE, ids[k], bursts[k]);
    end
    send_request(srt_pkg::OP_ARRIVE, 8'h7E, 16'd3);
    // Two one-tick tasks tie first; after them several tasks tie at two.
    repeat (3) send_request(srt_pkg::OP_TICK, 8'h00, 16'h0000);
  endtask

  // Random traffic in segments. Most segments are a run of arrivals followed
  // by a run of ticks, so the table swings between full and empty. The rest
  // interleave both kinds at random. One segment starts the long hold-off.
  task automatic run_random_traffic(int quota);
    int stop_at;
    bit hold_sent;
    stop_at   = requests_sent + quota;
    hold_sent = 1'b0;
    while (requests_sent < stop_at) begin
      tx_idling = ($urandom_range(0, 3) != 0);
      rx_idling = ($urandom_range(0, 3) != 0);
      if (!hold_sent && requests_sent > stop_at - quota / 2) begin
        holds_requested++;
        hold_sent = 1'b1;
      end
      if ($urandom_range(0, 9) < 2) begin
        repeat (20) begin
          if ($urandom_range(0, 1) == 0) begin
            send_request(srt_pkg::OP_ARRIVE, 8'($urandom_range(0, 255)), pick_burst());
          end else begin
            send_random_tick();
          end
        end
      end else begin
        repeat ($urandom_range(1, 18)) begin
          send_request(srt_pkg::OP_ARRIVE, 8'($urandom_range(0, 255)), pick_burst());
        end
        repeat ($urandom_range(1, 60)) send_random_tick();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence. Reset is held low at the start and released once.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    // The sender pauses here until every result is back.
    wait_drained();
    run_random_traffic(RANDOM_REQUESTS / 2);
    wait_drained();
    run_random_traffic(RANDOM_REQUESTS / 2);
    wait_drained();
    // Idle before the final check so that a stray result can still show up.
    repeat (SLOTS + 8) @(posedge clk);
    if (sb.pending_results.size() != 0) begin
      sb.report($sformatf("%0d expected results never arrived", sb.pending_results.size()));
    end
    if (sb.mismatches == 0) begin
      $display("** shortest_remaining_time_scheduler: PASSED **");
    end else begin
      $display("** shortest_remaining_time_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
